[hdl/sgv_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgv_pkg
// shared types, register indexes and helpers of the softened gravity step
// ----------------------------------------------------------------------------
package sgv_pkg;

    typedef struct packed {
        logic               op;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [15:0]        src_mass;
        logic               last_source;
    } sgv_in_t;

    typedef struct packed {
        logic signed [31:0] new_x;
        logic signed [31:0] new_y;
    } sgv_out_t;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SOURCE = 1'b1;

    localparam logic [1:0] CFG_GRAV_CONST = 2'd0;
    localparam logic [1:0] CFG_SOFT_SQ    = 2'd1;
    localparam logic [1:0] CFG_STEP_SQ    = 2'd2;

    localparam logic [31:0] GRAV_CONST_RESET = 32'd65536;
    localparam logic [31:0] SOFT_SQ_RESET    = 32'd65536;
    localparam logic [31:0] STEP_SQ_RESET    = 32'd1193046;

    typedef enum logic [1:0] {
        UNIT_MUL,
        UNIT_DIV,
        UNIT_SQRT
    } sgv_unit_op_t;

    typedef struct packed {
        logic         start;
        sgv_unit_op_t op;
        logic [63:0]  a;
        logic [63:0]  b;
    } sgv_unit_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] result;
    } sgv_unit_rsp_t;

    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        logic signed [31:0] r;
        if (v > 35'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -35'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic [30:0] sat31(input logic [63:0] v);
        logic [30:0] r;
        if (v[63:31] != 33'd0)
            r = 31'h7FFFFFFF;
        else
            r = v[30:0];
        return r;
    endfunction

endpackage

[hdl/softened_gravity_verlet_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// softened_gravity_verlet_step
// one body's softened gravity accumulation and position verlet update
// ----------------------------------------------------------------------------
// A load request is taken in the idle state. A source request runs through a
// single shared bit-serial unit, one pass per step: two squares, a square
// root, a mass product and a force division, then per axis a product and a
// division; a source that coincides with the body stops after the square
// root. The last source adds two step products and a hand-over state for
// the result, which waits while the previous result is unread.
// New requests are taken only between requests.
module softened_gravity_verlet_step (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  sgv_pkg::sgv_in_t  item,
    output logic              result_valid,
    input  logic              result_ready,
    output sgv_pkg::sgv_out_t result,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_data
);
    import sgv_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SQX, S_SQY, S_SQRT, S_GM, S_F, S_FX, S_CX,
        S_FY, S_CY, S_IX, S_IY, S_OUT
    } state_t;

    state_t             state_reg;
    logic               wait_reg;
    logic [31:0]        grav_reg, soft_reg, step_reg;
    logic signed [31:0] cur_x_reg, cur_y_reg, old_x_reg, old_y_reg;
    logic signed [31:0] acc_x_reg, acc_y_reg;
    logic signed [31:0] nx_reg, ny_reg;
    logic [31:0]        ax_reg, ay_reg;
    logic               sx_reg, sy_reg, last_reg;
    logic [15:0]        mass_reg;
    logic [63:0]        sqx_reg, sqy_reg, tmp_reg;
    logic [32:0]        len_reg;
    logic [30:0]        f_reg;
    logic               result_valid_reg;
    sgv_out_t           result_reg;

    sgv_unit_req_t      req;
    sgv_unit_rsp_t      rsp;

    logic               accept;
    logic signed [32:0] dx, dy;
    logic [32:0]        mdx, mdy;
    logic [31:0]        mag_acc_x, mag_acc_y;
    logic [30:0]        c_sat;
    logic signed [34:0] cterm, sum_x, sum_y, iterm, isum;
    logic signed [31:0] acc_pick, cur_pick, old_pick;
    logic               sgn_pick;

    assign item_ready   = (state_reg == S_IDLE);
    assign accept       = item_valid && item_ready;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign dx  = {item.pos_x[31], item.pos_x} - {cur_x_reg[31], cur_x_reg};
    assign dy  = {item.pos_y[31], item.pos_y} - {cur_y_reg[31], cur_y_reg};
    assign mdx = dx[32] ? 33'(-dx) : 33'(dx);
    assign mdy = dy[32] ? 33'(-dy) : 33'(dy);

    assign mag_acc_x = acc_x_reg[31] ? 32'(-acc_x_reg) : 32'(acc_x_reg);
    assign mag_acc_y = acc_y_reg[31] ? 32'(-acc_y_reg) : 32'(acc_y_reg);

    // signed per-axis pull and saturating accumulate
    assign c_sat    = sat31(rsp.result);
    assign sgn_pick = (state_reg == S_CX) ? sx_reg : sy_reg;
    assign cterm    = sgn_pick ? -$signed({4'b0000, c_sat}) : $signed({4'b0000, c_sat});
    assign sum_x    = $signed({{3{acc_x_reg[31]}}, acc_x_reg}) + cterm;
    assign sum_y    = $signed({{3{acc_y_reg[31]}}, acc_y_reg}) + cterm;

    // verlet: 2*cur - old + acc*dt^2
    assign acc_pick = (state_reg == S_IX) ? acc_x_reg : acc_y_reg;
    assign cur_pick = (state_reg == S_IX) ? cur_x_reg : cur_y_reg;
    assign old_pick = (state_reg == S_IX) ? old_x_reg : old_y_reg;
    assign iterm    = acc_pick[31] ? -$signed({3'b000, rsp.result[63:32]})
                                   : $signed({3'b000, rsp.result[63:32]});
    assign isum     = $signed({{2{cur_pick[31]}}, cur_pick, 1'b0})
                    - $signed({{3{old_pick[31]}}, old_pick}) + iterm;

    always_comb
    begin
        req.start = 1'b0;
        req.op    = UNIT_MUL;
        req.a     = 64'd0;
        req.b     = 64'd0;
        unique case (state_reg)
            S_SQX:
            begin
                req.a = {32'd0, ax_reg};
                req.b = {32'd0, ax_reg};
            end
            S_SQY:
            begin
                req.a = {32'd0, ay_reg};
                req.b = {32'd0, ay_reg};
            end
            S_SQRT:
            begin
                req.op = UNIT_SQRT;
                req.a  = {2'b00, sqx_reg[63:2]} + {2'b00, sqy_reg[63:2]};
            end
            S_GM:
            begin
                req.a = {32'd0, grav_reg};
                req.b = {48'd0, mass_reg};
            end
            S_F:
            begin
                req.op = UNIT_DIV;
                req.a  = {tmp_reg[47:0], 16'd0};
                req.b  = {16'd0, sqx_reg[63:16]} + {16'd0, sqy_reg[63:16]}
                       + {32'd0, soft_reg};
            end
            S_FX:
            begin
                req.a = {33'd0, f_reg};
                req.b = {32'd0, ax_reg};
            end
            S_FY:
            begin
                req.a = {33'd0, f_reg};
                req.b = {32'd0, ay_reg};
            end
            S_CX, S_CY:
            begin
                req.op = UNIT_DIV;
                req.a  = tmp_reg;
                req.b  = {31'd0, len_reg};
            end
            S_IX:
            begin
                req.a = {32'd0, mag_acc_x};
                req.b = {32'd0, step_reg};
            end
            S_IY:
            begin
                req.a = {32'd0, mag_acc_y};
                req.b = {32'd0, step_reg};
            end
            default:
            begin
                req.op = UNIT_MUL;
            end
        endcase
        if (state_reg != S_IDLE && state_reg != S_OUT && !wait_reg)
            req.start = 1'b1;
    end

    sgv_serial_unit u_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            wait_reg         <= 1'b0;
            grav_reg         <= GRAV_CONST_RESET;
            soft_reg         <= SOFT_SQ_RESET;
            step_reg         <= STEP_SQ_RESET;
            cur_x_reg        <= 32'sd0;
            cur_y_reg        <= 32'sd0;
            old_x_reg        <= 32'sd0;
            old_y_reg        <= 32'sd0;
            acc_x_reg        <= 32'sd0;
            acc_y_reg        <= 32'sd0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_GRAV_CONST: grav_reg <= cfg_data;
                    CFG_SOFT_SQ:    soft_reg <= cfg_data;
                    CFG_STEP_SQ:    step_reg <= cfg_data;
                    default:        grav_reg <= grav_reg;
                endcase
            end

            if (result_valid_reg && result_ready && state_reg != S_OUT)
                result_valid_reg <= 1'b0;

            if (req.start)
                wait_reg <= 1'b1;
            if (rsp.done)
                wait_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (item.op == OP_LOAD)
                        begin
                            cur_x_reg <= item.pos_x;
                            cur_y_reg <= item.pos_y;
                            old_x_reg <= item.pos_x;
                            old_y_reg <= item.pos_y;
                            acc_x_reg <= 32'sd0;
                            acc_y_reg <= 32'sd0;
                        end
                        else
                        begin
                            ax_reg    <= mdx[31:0];
                            ay_reg    <= mdy[31:0];
                            sx_reg    <= dx[32];
                            sy_reg    <= dy[32];
                            mass_reg  <= item.src_mass;
                            last_reg  <= item.last_source;
                            state_reg <= S_SQX;
                        end
                    end
                end
                S_SQX:
                begin
                    if (rsp.done)
                    begin
                        sqx_reg   <= rsp.result;
                        state_reg <= S_SQY;
                    end
                end
                S_SQY:
                begin
                    if (rsp.done)
                    begin
                        sqy_reg   <= rsp.result;
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT:
                begin
                    if (rsp.done)
                    begin
                        len_reg <= {rsp.result[31:0], 1'b0};
                        // coincident source adds nothing
                        if (rsp.result[31:0] == 32'd0)
                            state_reg <= last_reg ? S_IX : S_IDLE;
                        else
                            state_reg <= S_GM;
                    end
                end
                S_GM:
                begin
                    if (rsp.done)
                    begin
                        tmp_reg   <= rsp.result;
                        state_reg <= S_F;
                    end
                end
                S_F:
                begin
                    if (rsp.done)
                    begin
                        f_reg     <= sat31(rsp.result);
                        state_reg <= S_FX;
                    end
                end
                S_FX:
                begin
                    if (rsp.done)
                    begin
                        tmp_reg   <= rsp.result;
                        state_reg <= S_CX;
                    end
                end
                S_CX:
                begin
                    if (rsp.done)
                    begin
                        acc_x_reg <= sat32(sum_x);
                        state_reg <= S_FY;
                    end
                end
                S_FY:
                begin
                    if (rsp.done)
                    begin
                        tmp_reg   <= rsp.result;
                        state_reg <= S_CY;
                    end
                end
                S_CY:
                begin
                    if (rsp.done)
                    begin
                        acc_y_reg <= sat32(sum_y);
                        state_reg <= last_reg ? S_IX : S_IDLE;
                    end
                end
                S_IX:
                begin
                    if (rsp.done)
                    begin
                        nx_reg    <= sat32(isum);
                        state_reg <= S_IY;
                    end
                end
                S_IY:
                begin
                    if (rsp.done)
                    begin
                        ny_reg    <= sat32(isum);
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!result_valid_reg || result_ready)
                    begin
                        result_reg.new_x <= nx_reg;
                        result_reg.new_y <= ny_reg;
                        result_valid_reg <= 1'b1;
                        old_x_reg        <= cur_x_reg;
                        old_y_reg        <= cur_y_reg;
                        cur_x_reg        <= nx_reg;
                        cur_y_reg        <= ny_reg;
                        acc_x_reg        <= 32'sd0;
                        acc_y_reg        <= 32'sd0;
                        state_reg        <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_idle_unit_free: assert property (@(posedge clk) disable iff (!rst_n)
        item_ready |-> !rsp.busy)
        else $error("serial unit busy while taking requests");

    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg == S_OUT))
        else $error("result raised outside hand-over");

    a_load_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.op == OP_LOAD) |=> (acc_x_reg == 32'sd0 && acc_y_reg == 32'sd0))
        else $error("load left accumulator set");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> $past(rsp.busy))
        else $error("unit done without work");
`endif

endmodule

[hdl/sgv_serial_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgv_serial_unit
// shared bit-serial multiplier, restoring divider and square root
// ----------------------------------------------------------------------------
module sgv_serial_unit (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sgv_pkg::sgv_unit_req_t req,
    output sgv_pkg::sgv_unit_rsp_t rsp
);
    import sgv_pkg::*;

    sgv_unit_op_t op_reg;
    logic         busy_reg;
    logic         done_reg;
    logic [5:0]   cnt_reg;
    logic [63:0]  a_reg;
    logic [63:0]  b_reg;
    logic [65:0]  r_reg;

    logic [65:0] div_sh;
    logic [65:0] sq_sh;
    logic [65:0] sq_trial;
    logic [5:0]  last_cnt;

    assign div_sh   = {1'b0, r_reg[63:0], a_reg[63]};
    assign sq_sh    = {r_reg[63:0], a_reg[63:62]};
    assign sq_trial = {b_reg, 2'b01};
    assign last_cnt = (op_reg == UNIT_DIV) ? 6'd63 : 6'd31;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg   <= UNIT_MUL;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                op_reg   <= req.op;
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd0;
                a_reg    <= req.a;
                b_reg    <= req.b;
                r_reg    <= 66'd0;
            end
            else if (busy_reg)
            begin
                unique case (op_reg)
                    UNIT_MUL:
                    begin
                        if (b_reg[0])
                            r_reg <= r_reg + {2'b00, a_reg};
                        a_reg <= {a_reg[62:0], 1'b0};
                        b_reg <= {1'b0, b_reg[63:1]};
                    end
                    UNIT_DIV:
                    begin
                        if (div_sh >= {2'b00, b_reg})
                        begin
                            r_reg <= div_sh - {2'b00, b_reg};
                            a_reg <= {a_reg[62:0], 1'b1};
                        end
                        else
                        begin
                            r_reg <= div_sh;
                            a_reg <= {a_reg[62:0], 1'b0};
                        end
                    end
                    UNIT_SQRT:
                    begin
                        a_reg <= {a_reg[61:0], 2'b00};
                        if (sq_sh >= sq_trial)
                        begin
                            r_reg <= sq_sh - sq_trial;
                            b_reg <= {b_reg[62:0], 1'b1};
                        end
                        else
                        begin
                            r_reg <= sq_sh;
                            b_reg <= {b_reg[62:0], 1'b0};
                        end
                    end
                    default:
                    begin
                        r_reg <= r_reg;
                    end
                endcase
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == last_cnt)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        rsp.busy = busy_reg;
        rsp.done = done_reg;
        unique case (op_reg)
            UNIT_MUL:  rsp.result = r_reg[63:0];
            UNIT_DIV:  rsp.result = a_reg;
            UNIT_SQRT: rsp.result = b_reg;
            default:   rsp.result = 64'd0;
        endcase
    end

endmodule

[sim/softened_gravity_verlet_step_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// softened_gravity_verlet_step_tb
// Checks the one-body gravity step against a fixed-point predictor of its
// own. Load and source requests run in phases under several register
// settings. The sender works in bursts with gaps and the receiver stalls,
// once for a long stretch. Every result is compared with the predicted
// new position.
// ----------------------------------------------------------------------------
module softened_gravity_verlet_step_tb;
    import sgv_pkg::*;

    localparam int SETTLE_CYCLES = 600;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LONG_HOLD = 4000;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_ready;
    sgv_in_t     item;
    logic        result_valid;
    logic        result_ready;
    sgv_out_t    result;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    sgv_in_t  pending_requests[$];
    sgv_out_t expected_positions[$];

    logic [31:0]        grav_reg;
    logic [31:0]        soft_reg;
    logic [31:0]        step_reg;
    logic signed [31:0] body_x;
    logic signed [31:0] body_y;
    logic signed [31:0] prev_x;
    logic signed [31:0] prev_y;
    logic signed [31:0] pull_x;
    logic signed [31:0] pull_y;

    int mismatches = 0;
    int results_seen = 0;
    int burst_left = 0;
    int gap_left = 0;
    int hold_left = 0;
    int stall_mode = 0;
    int idle_cycles = 0;
    bit held_once = 0;

    softened_gravity_verlet_step i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic logic signed [31:0] clamp_q16(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic bit [63:0] root_floor(bit [63:0] s);
        bit [63:0] res;
        bit [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > s)
            b = b >> 2;
        while (b != 0)
        begin
            if (s >= res + b)
            begin
                s = s - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [31:0] verlet_axis(logic signed [31:0] now,
                                                       logic signed [31:0] was,
                                                       logic signed [31:0] acc);
        bit [63:0] mag;
        longint    term;
        mag = (acc < 0) ? 64'(-longint'(acc)) : 64'(longint'(acc));
        term = longint'((mag * 64'(step_reg)) >> 32);
        if (acc < 0)
            term = -term;
        return clamp_q16(2 * longint'(now) - longint'(was) + term);
    endfunction

    task automatic add_pull(logic signed [31:0] px, logic signed [31:0] py,
                            logic [15:0] mass);
        longint    dx;
        longint    dy;
        bit [63:0] ax;
        bit [63:0] ay;
        bit [63:0] sqx;
        bit [63:0] sqy;
        bit [63:0] len;
        bit [63:0] r2;
        bit [63:0] f;
        bit [63:0] cx;
        bit [63:0] cy;
        dx = longint'(px) - longint'(body_x);
        dy = longint'(py) - longint'(body_y);
        ax = (dx < 0) ? 64'(-dx) : 64'(dx);
        ay = (dy < 0) ? 64'(-dy) : 64'(dy);
        sqx = ax * ax;
        sqy = ay * ay;
        len = 2 * root_floor((sqx >> 2) + (sqy >> 2));
        if (len == 0)
            return;
        r2 = (sqx >> 16) + (sqy >> 16) + 64'(soft_reg);
        if (r2 == 0)
            f = 64'h7FFFFFFF;
        else
            f = ((64'(grav_reg) * 64'(mass)) << 16) / r2;
        if (f > 64'h7FFFFFFF)
            f = 64'h7FFFFFFF;
        cx = f * ax / len;
        cy = f * ay / len;
        if (cx > 64'h7FFFFFFF)
            cx = 64'h7FFFFFFF;
        if (cy > 64'h7FFFFFFF)
            cy = 64'h7FFFFFFF;
        pull_x = clamp_q16(longint'(pull_x) + ((dx < 0) ? -longint'(cx) : longint'(cx)));
        pull_y = clamp_q16(longint'(pull_y) + ((dy < 0) ? -longint'(cy) : longint'(cy)));
    endtask

    task automatic step_body(sgv_in_t r);
        sgv_out_t o;
        if (r.op == OP_LOAD)
        begin
            body_x = r.pos_x;
            prev_x = r.pos_x;
            body_y = r.pos_y;
            prev_y = r.pos_y;
            pull_x = 0;
            pull_y = 0;
            return;
        end
        add_pull(r.pos_x, r.pos_y, r.src_mass);
        if (!r.last_source)
            return;
        o.new_x = verlet_axis(body_x, prev_x, pull_x);
        o.new_y = verlet_axis(body_y, prev_y, pull_y);
        prev_x = body_x;
        prev_y = body_y;
        body_x = o.new_x;
        body_y = o.new_y;
        pull_x = 0;
        pull_y = 0;
        expected_positions.insert(expected_positions.size(), o);
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("result %0d: %s got %h want %h", results_seen, what, got, want);
        mismatches++;
    endtask

    function automatic void queue_request(sgv_in_t r);
        pending_requests.insert(pending_requests.size(), r);
    endfunction

    // sender: bursts of requests with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item <= '0;
        end
        else
        begin
            if (item_valid && item_ready)
                step_body(item);
            if (item_valid && !item_ready)
                item_valid <= 1'b1;
            else if (gap_left > 0)
            begin
                gap_left--;
                item_valid <= 1'b0;
            end
            else if (pending_requests.size() > 0)
            begin
                item <= pending_requests.pop_front();
                item_valid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 600);
                end
                else
                    burst_left--;
            end
            else
                item_valid <= 1'b0;
        end
    end

    // receiver: stall pattern plus one long hold
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_positions.size() == 0)
                    report_mismatch("unexpected new_x", result.new_x, 32'h0);
                else
                begin
                    if (result.new_x !== expected_positions[0].new_x)
                        report_mismatch("new_x", result.new_x, expected_positions[0].new_x);
                    if (result.new_y !== expected_positions[0].new_y)
                        report_mismatch("new_y", result.new_y, expected_positions[0].new_y);
                    void'(expected_positions.pop_front());
                end
                results_seen++;
                if ($urandom_range(0, 15) == 0)
                    stall_mode = $urandom_range(0, 2);
            end
            if (!held_once && results_seen == 20)
            begin
                held_once = 1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else if (stall_mode == 0)
                result_ready <= 1'b1;
            else if (stall_mode == 1)
                result_ready <= ($urandom_range(0, 3) != 0);
            else
                result_ready <= ($urandom_range(0, 9) == 0);
        end
    end

    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("softened_gravity_verlet_step: mismatch");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            CFG_GRAV_CONST: grav_reg = value;
            CFG_SOFT_SQ:    soft_reg = value;
            CFG_STEP_SQ:    step_reg = value;
            default: ;
        endcase
    endtask

    task automatic set_regs(logic [31:0] g, logic [31:0] s, logic [31:0] t);
        write_reg(CFG_GRAV_CONST, g);
        write_reg(CFG_SOFT_SQ, s);
        write_reg(CFG_STEP_SQ, t);
        write_reg(2'd3, $urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_requests.size() > 0 || item_valid || expected_positions.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic sgv_in_t make_req(logic op, logic signed [31:0] x,
                                         logic signed [31:0] y, logic [15:0] m,
                                         logic last);
        sgv_in_t r;
        r.op = op;
        r.pos_x = x;
        r.pos_y = y;
        r.src_mass = m;
        r.last_source = last;
        return r;
    endfunction

    function automatic logic signed [31:0] pick_coord(logic signed [31:0] centre);
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return centre + $signed(32'($urandom_range(0, 2000))) - 1000;
            default: return centre + $signed(32'($urandom_range(0, 32'h00FFFFFF)))
                            - 32'sh00800000;
        endcase
    endfunction

    task automatic queue_random(int count);
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        int n;
        int k;
        n = 0;
        while (n < count)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                // noise: stray load or source with a random last flag
                queue_request(make_req(1'($urandom_range(0, 1)), $urandom, $urandom,
                                       16'($urandom), 1'($urandom_range(0, 1))));
                n++;
            end
            else
            begin
                cx = ($urandom_range(0, 3) == 0) ? $urandom
                                                 : $signed(32'($urandom_range(0, 32'h03FFFFFF)))
                                                   - 32'sh02000000;
                cy = ($urandom_range(0, 3) == 0) ? $urandom
                                                 : $signed(32'($urandom_range(0, 32'h03FFFFFF)))
                                                   - 32'sh02000000;
                queue_request(make_req(OP_LOAD, cx, cy, 16'($urandom),
                                       1'($urandom_range(0, 1))));
                k = $urandom_range(1, 4);
                for (int i = 0; i < k; i++)
                    queue_request(make_req(OP_SOURCE, pick_coord(cx), pick_coord(cy),
                                           16'($urandom), i == k - 1));
                n += k + 1;
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        grav_reg = GRAV_CONST_RESET;
        soft_reg = SOFT_SQ_RESET;
        step_reg = STEP_SQ_RESET;
        body_x = 0;
        body_y = 0;
        prev_x = 0;
        prev_y = 0;
        pull_x = 0;
        pull_y = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // sources before any load, coincident and one raw step away
        queue_request(make_req(OP_SOURCE, 32'sh00010000, 32'sh00020000, 16'd5, 1'b0));
        queue_request(make_req(OP_SOURCE, 0, 0, 16'hFFFF, 1'b0));
        queue_request(make_req(OP_SOURCE, 32'sd1, 0, 16'hFFFF, 1'b1));
        // load carrying the last flag, then extremes of position and mass
        queue_request(make_req(OP_LOAD, 32'sh7FFFFFFF, 32'sh80000000, 16'hFFFF, 1'b1));
        queue_request(make_req(OP_SOURCE, 32'sh80000000, 32'sh7FFFFFFF, 16'hFFFF, 1'b0));
        queue_request(make_req(OP_SOURCE, 32'sh7FFFFFFF, 32'sh80000000, 16'h0000, 1'b0));
        queue_request(make_req(OP_SOURCE, 32'sh7FFF0000, 32'sh80010000, 16'd1, 1'b1));
        queue_request(make_req(OP_LOAD, 0, 0, 16'd0, 1'b0));
        queue_request(make_req(OP_SOURCE, 32'sh00030000, 32'shFFFC0000, 16'd100, 1'b1));
        queue_random(150);
        wait_idle();

        // extremes: strongest pull, no softening, longest step
        set_regs(32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF);
        // zero denominator with a non-zero direction
        queue_request(make_req(OP_LOAD, 32'sh00100000, 32'sh00100000, 16'd0, 1'b0));
        queue_request(make_req(OP_SOURCE, 32'sh00100002, 32'sh00100000, 16'd1, 1'b0));
        queue_request(make_req(OP_SOURCE, 32'sh000FFFF0, 32'sh00100005, 16'hFFFF, 1'b1));
        queue_request(make_req(OP_SOURCE, 32'sh80000000, 32'sh80000000, 16'hFFFF, 1'b1));
        queue_random(150);
        wait_idle();

        set_regs(32'h0, 32'hFFFFFFFF, 32'h0);
        queue_random(120);
        wait_idle();

        set_regs($urandom_range(1, 32'h00100000), $urandom_range(0, 32'h00040000), $urandom);
        queue_random(150);
        wait_idle();

        if (mismatches == 0 && expected_positions.size() == 0)
            $display("softened_gravity_verlet_step: match");
        else
            $display("softened_gravity_verlet_step: mismatch");
        $finish;
    end

endmodule

[filelist.f]
hdl/sgv_pkg.sv
hdl/sgv_serial_unit.sv
hdl/softened_gravity_verlet_step.sv
sim/softened_gravity_verlet_step_tb.sv
